@@ rtl/ssc_pkg.sv @@
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int PAR_W   = 32;

  localparam int D_W     = COORD_W + 1;          // coordinate difference
  localparam int PROD_W  = 2 * D_W;              // one product of differences
  localparam int DOT_W   = PROD_W + 2;           // sum of three products
  localparam int HALF_W  = DOT_W / 2;            // split point for wide products
  localparam int PP_W    = 2 * HALF_W + 3;       // partial product
  localparam int WIDE_W  = 2 * DOT_W + 4;        // determinant, numerators, tn
  localparam int MP_W    = HALF_W + PAR_W + 3;   // b * s partials
  localparam int ALONG_W = D_W + PAR_W + 2;      // d * param

  localparam int IN_W  = ((12 * COORD_W + 7) / 8) * 8;
  localparam int OUT_W = ((6 * COORD_W + 7) / 8) * 8;

  localparam longint unsigned EPS_Q =
    ((64'd1 << (2 * FRAC_W)) + 64'd500000) / 64'd1000000;

  typedef logic [PAR_W:0] par_t;
  localparam par_t PAR_ONE = {1'b1, {PAR_W{1'b0}}};

  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [2:0][COORD_W-1:0]  vec_c_t;
  typedef logic [2:0][D_W-1:0]      vec_d_t;

  typedef struct packed {
    vec_c_t p1;
    vec_c_t p2;
    vec_d_t d1;
    vec_d_t d2;
  } geo_t;

  typedef struct packed {
    geo_t  g;
    dot_t  a;
    dot_t  e;
    dot_t  b;
    dot_t  c;
    dot_t  f;
    logic  a_deg;
    logic  e_deg;
    par_t  s;
    par_t  t;
    logic  tn_neg;
    logic  tn_gt;
  } side_t;

endpackage

@@ rtl/ssc_front.sv @@
`timescale 1ns / 1ps

// Differences, dot products and degeneracy flags: three stages.
module ssc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [ssc_pkg::IN_W-1:0] data_i,
  output logic                    valid_o,
  output ssc_pkg::side_t          side_o
);

  localparam int C = ssc_pkg::COORD_W;

  // stage 1: differences
  ssc_pkg::geo_t   g1_d, g1_q;
  ssc_pkg::vec_d_t r1_d, r1_q;
  logic            v1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g1_d.p1[i] = data_i[i*C +: C];
      g1_d.p2[i] = data_i[(6+i)*C +: C];
      g1_d.d1[i] = ssc_pkg::D_W'($signed(data_i[(3+i)*C +: C]))
                 - ssc_pkg::D_W'($signed(data_i[i*C +: C]));
      g1_d.d2[i] = ssc_pkg::D_W'($signed(data_i[(9+i)*C +: C]))
                 - ssc_pkg::D_W'($signed(data_i[(6+i)*C +: C]));
      r1_d[i]    = ssc_pkg::D_W'($signed(data_i[i*C +: C]))
                 - ssc_pkg::D_W'($signed(data_i[(6+i)*C +: C]));
    end
  end

  // stage 2: products
  logic signed [ssc_pkg::PROD_W-1:0] pa_d [3], pe_d [3], pb_d [3], pc_d [3], pf_d [3];
  logic signed [ssc_pkg::PROD_W-1:0] pa_q [3], pe_q [3], pb_q [3], pc_q [3], pf_q [3];
  ssc_pkg::geo_t g2_q;
  logic          v2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_d[i] = $signed(g1_q.d1[i]) * $signed(g1_q.d1[i]);
      pe_d[i] = $signed(g1_q.d2[i]) * $signed(g1_q.d2[i]);
      pb_d[i] = $signed(g1_q.d1[i]) * $signed(g1_q.d2[i]);
      pc_d[i] = $signed(g1_q.d1[i]) * $signed(r1_q[i]);
      pf_d[i] = $signed(g1_q.d2[i]) * $signed(r1_q[i]);
    end
  end

  // stage 3: sums and flags
  ssc_pkg::side_t side3_d, side3_q;
  logic           v3_q;

  always_comb begin
    side3_d       = '0;
    side3_d.g     = g2_q;
    side3_d.a     = pa_q[0] + pa_q[1] + pa_q[2];
    side3_d.e     = pe_q[0] + pe_q[1] + pe_q[2];
    side3_d.b     = pb_q[0] + pb_q[1] + pb_q[2];
    side3_d.c     = pc_q[0] + pc_q[1] + pc_q[2];
    side3_d.f     = pf_q[0] + pf_q[1] + pf_q[2];
    side3_d.a_deg = side3_d.a <= $signed(ssc_pkg::DOT_W'(ssc_pkg::EPS_Q));
    side3_d.e_deg = side3_d.e <= $signed(ssc_pkg::DOT_W'(ssc_pkg::EPS_Q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_q    <= g1_d;
      r1_q    <= r1_d;
      g2_q    <= g1_q;
      pa_q    <= pa_d;
      pe_q    <= pe_d;
      pb_q    <= pb_d;
      pc_q    <= pc_d;
      pf_q    <= pf_d;
      side3_q <= side3_d;
    end
  end

  assign valid_o = v3_q;
  assign side_o  = side3_q;

endmodule

@@ rtl/ssc_solve.sv @@
`timescale 1ns / 1ps

// a*e, b*b, b*f, c*e from split partial products; determinant, numerator
// and operand select for the first divider. Five stages.
module ssc_solve (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  ssc_pkg::side_t        side_i,
  output logic                  valid_o,
  output ssc_pkg::wide_t        nhi_o,
  output ssc_pkg::wide_t        den_o,
  output ssc_pkg::side_t        side_o
);

  localparam int H = ssc_pkg::HALF_W;

  ssc_pkg::dot_t opx [4], opy [4];

  always_comb begin
    opx[0] = side_i.a; opy[0] = side_i.e;
    opx[1] = side_i.b; opy[1] = side_i.b;
    opx[2] = side_i.b; opy[2] = side_i.f;
    opx[3] = side_i.c; opy[3] = side_i.e;
  end

  // stage 4: partials, hi part signed, lo part zero-extended
  logic signed [ssc_pkg::PP_W-1:0] hh_d [4], hl_d [4], lh_d [4], ll_d [4];
  logic signed [ssc_pkg::PP_W-1:0] hh_q [4], hl_q [4], lh_q [4], ll_q [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hh_d[k] = $signed(opx[k][ssc_pkg::DOT_W-1:H]) * $signed(opy[k][ssc_pkg::DOT_W-1:H]);
      hl_d[k] = $signed(opx[k][ssc_pkg::DOT_W-1:H]) * $signed({1'b0, opy[k][H-1:0]});
      lh_d[k] = $signed({1'b0, opx[k][H-1:0]}) * $signed(opy[k][ssc_pkg::DOT_W-1:H]);
      ll_d[k] = $signed({1'b0, opx[k][H-1:0]}) * $signed({1'b0, opy[k][H-1:0]});
    end
  end

  // stage 5: cross terms
  logic signed [ssc_pkg::PP_W:0]   cr_q [4];
  logic signed [ssc_pkg::PP_W-1:0] hh5_q [4], ll5_q [4];

  // stage 6: full products
  ssc_pkg::wide_t pr_d [4], pr_q [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pr_d[k] = (ssc_pkg::WIDE_W'(hh5_q[k]) <<< (2 * H))
              + (ssc_pkg::WIDE_W'(cr_q[k]) <<< H)
              + ssc_pkg::WIDE_W'(ll5_q[k]);
    end
  end

  // stage 7: determinant and numerator
  ssc_pkg::wide_t det_q, num_q;

  // side data, one entry per stage 4..8
  ssc_pkg::side_t side_q [5];
  logic           v_q    [5];

  // stage 8: divider operands
  ssc_pkg::wide_t nhi_d, den_d, nhi_q, den_q;

  always_comb begin
    if (side_q[3].a_deg) begin
      nhi_d = ssc_pkg::WIDE_W'(side_q[3].f);
      den_d = ssc_pkg::WIDE_W'(side_q[3].e);
    end else if (side_q[3].e_deg) begin
      nhi_d = -ssc_pkg::WIDE_W'(side_q[3].c);
      den_d = ssc_pkg::WIDE_W'(side_q[3].a);
    end else if (det_q == '0) begin
      // parallel: s = 0
      nhi_d = '0;
      den_d = ssc_pkg::WIDE_W'(1);
    end else begin
      nhi_d = num_q;
      den_d = det_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < 5; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q      <= hh_d;
      hl_q      <= hl_d;
      lh_q      <= lh_d;
      ll_q      <= ll_d;
      for (int k = 0; k < 4; k++) begin
        cr_q[k]  <= (ssc_pkg::PP_W+1)'(hl_q[k]) + (ssc_pkg::PP_W+1)'(lh_q[k]);
      end
      hh5_q     <= hh_q;
      ll5_q     <= ll_q;
      pr_q      <= pr_d;
      det_q     <= pr_q[0] - pr_q[1];
      num_q     <= pr_q[2] - pr_q[3];
      nhi_q     <= nhi_d;
      den_q     <= den_d;
      side_q[0] <= side_i;
      for (int k = 1; k < 5; k++) side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = v_q[4];
  assign nhi_o   = nhi_q;
  assign den_o   = den_q;
  assign side_o  = side_q[4];

endmodule

@@ rtl/ssc_div.sv @@
`timescale 1ns / 1ps

// Clamped quotient floor((nhi * 2^PAR_W + nlo) / den), one quotient bit per
// stage. nhi < 0 gives 0, nhi >= den gives ONE.
module ssc_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  ssc_pkg::wide_t           nhi_i,
  input  logic [ssc_pkg::PAR_W-1:0] nlo_i,
  input  ssc_pkg::wide_t           den_i,
  input  ssc_pkg::side_t           side_i,
  output logic                     valid_o,
  output ssc_pkg::par_t            q_o,
  output ssc_pkg::side_t           side_o
);

  localparam int N = ssc_pkg::PAR_W;
  localparam int W = ssc_pkg::WIDE_W;

  logic                v_q    [N+1];
  logic [W-1:0]        rem_q  [N+1];
  logic [W-1:0]        den_q  [N+1];
  logic [N-1:0]        lo_q   [N+1];
  logic [N-1:0]        quo_q  [N+1];
  logic                one_q  [N+1];
  ssc_pkg::side_t      side_q [N+1];

  logic neg_in, one_in;

  assign neg_in = nhi_i[W-1];
  assign one_in = !neg_in && (nhi_i >= den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= (neg_in || one_in) ? '0 : nhi_i;
      lo_q[0]   <= (neg_in || one_in) ? '0 : nlo_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      one_q[0]  <= one_in;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [W:0] sh, diff;
    logic       ge;

    always_comb begin
      sh   = {rem_q[k], lo_q[k][N-1]};
      diff = sh - {1'b0, den_q[k]};
      ge   = !diff[W];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? diff[W-1:0] : sh[W-1:0];
        lo_q[k+1]   <= {lo_q[k][N-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][N-2:0], ge};
        den_q[k+1]  <= den_q[k];
        one_q[k+1]  <= one_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[N];
  assign q_o     = one_q[N] ? ssc_pkg::PAR_ONE : {1'b0, quo_q[N]};
  assign side_o  = side_q[N];

endmodule

@@ rtl/ssc_mid.sv @@
`timescale 1ns / 1ps

// Places the first quotient, forms tn = b*s + f*ONE and picks the operands
// of the second divider. Three stages.
module ssc_mid (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  ssc_pkg::par_t             q_i,
  input  ssc_pkg::side_t            side_i,
  output logic                      valid_o,
  output ssc_pkg::wide_t            nhi_o,
  output logic [ssc_pkg::PAR_W-1:0] nlo_o,
  output ssc_pkg::wide_t            den_o,
  output ssc_pkg::side_t            side_o
);

  localparam int H = ssc_pkg::HALF_W;
  localparam int P = ssc_pkg::PAR_W;
  localparam int W = ssc_pkg::WIDE_W;

  // stage 1
  ssc_pkg::side_t side1_d, side1_q;
  logic signed [ssc_pkg::MP_W-1:0] pbh_d, pbl_d, pbh_q, pbl_q;

  always_comb begin
    side1_d = side_i;
    if (side_i.a_deg && side_i.e_deg) begin
      side1_d.s = '0;
      side1_d.t = '0;
    end else if (side_i.a_deg) begin
      side1_d.s = '0;
      side1_d.t = q_i;
    end else begin
      side1_d.s = q_i;
      side1_d.t = '0;
    end
    pbh_d = $signed(side_i.b[ssc_pkg::DOT_W-1:H]) * $signed({1'b0, side1_d.s});
    pbl_d = $signed({1'b0, side_i.b[H-1:0]}) * $signed({1'b0, side1_d.s});
  end

  // stage 2
  ssc_pkg::side_t side2_q;
  ssc_pkg::wide_t tn_q, nc_q, bmc_q;

  // stage 3
  logic           gen, neg, gt;
  ssc_pkg::side_t side3_d, side3_q;
  ssc_pkg::wide_t nhi_d, den_d, nhi_q, den_q;
  logic [P-1:0]   nlo_d, nlo_q;

  always_comb begin
    gen = !side2_q.a_deg && !side2_q.e_deg;
    neg = tn_q[W-1];
    gt  = tn_q > (W'(side2_q.e) <<< P);
    side3_d        = side2_q;
    side3_d.tn_neg = gen && neg;
    side3_d.tn_gt  = gen && !neg && gt;
    nlo_d = '0;
    if (neg) begin
      nhi_d = nc_q;
      den_d = W'(side2_q.a);
    end else if (gt) begin
      nhi_d = bmc_q;
      den_d = W'(side2_q.a);
    end else begin
      nhi_d = tn_q >>> P;
      nlo_d = tn_q[P-1:0];
      den_d = W'(side2_q.e);
    end
    // keep the unused divider path away from a zero divisor
    if (den_d == '0) den_d = W'(1);
  end

  logic v_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side1_d;
      pbh_q   <= pbh_d;
      pbl_q   <= pbl_d;
      side2_q <= side1_q;
      tn_q    <= (W'(pbh_q) <<< H) + W'(pbl_q) + (W'(side1_q.f) <<< P);
      nc_q    <= -W'(side1_q.c);
      bmc_q   <= W'(side1_q.b) - W'(side1_q.c);
      side3_q <= side3_d;
      nhi_q   <= nhi_d;
      nlo_q   <= nlo_d;
      den_q   <= den_d;
    end
  end

  assign valid_o = v_q[2];
  assign nhi_o   = nhi_q;
  assign nlo_o   = nlo_q;
  assign den_o   = den_q;
  assign side_o  = side3_q;

endmodule

@@ rtl/segment_segment_closest_points_unit.sv @@
`timescale 1ns / 1ps

// Channel | Dir | Width | Contents
// s_axis  | in  | 384   | one segment pair request
// m_axis  | out | 192   | closest point on each segment
//
// Fully pipelined: one request per cycle while m_axis does not stall. Stages from
// accept to result: 3 front, 5 solve, 33 + 3 + 33 for two bit-per-stage dividers, 2 output.
// The divider stages set the depth; each after a divider's input stage resolves one quotient bit.
// Reset clears the valid bits only; the datapath needs no reset.
// A stall on m_axis freezes every stage; s_axis_tready drops with it.
module segment_segment_closest_points_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // seg1_start_x/y/z, seg1_end_x/y/z, seg2_start_x/y/z, seg2_end_x/y/z, 32 b each
  input  logic [ssc_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // near1_x/y/z, near2_x/y/z, 32 b each
  output logic [ssc_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready
);

  localparam int C = ssc_pkg::COORD_W;
  localparam int P = ssc_pkg::PAR_W;
  localparam int A = ssc_pkg::ALONG_W;

  logic en;
  logic out_v_q;

  // whole pipe advances unless the output register is full and blocked
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  logic           fr_v;
  ssc_pkg::side_t fr_side;

  ssc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .valid_o (fr_v),
    .side_o  (fr_side)
  );

  logic           sv_v;
  ssc_pkg::wide_t sv_nhi, sv_den;
  ssc_pkg::side_t sv_side;

  ssc_solve u_solve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .side_i  (fr_side),
    .valid_o (sv_v),
    .nhi_o   (sv_nhi),
    .den_o   (sv_den),
    .side_o  (sv_side)
  );

  // first division: s, or t when segment 1 is a point
  logic           d1_v;
  ssc_pkg::par_t  d1_q;
  ssc_pkg::side_t d1_side;

  ssc_div u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv_v),
    .nhi_i   (sv_nhi),
    .nlo_i   ('0),
    .den_i   (sv_den),
    .side_i  (sv_side),
    .valid_o (d1_v),
    .q_o     (d1_q),
    .side_o  (d1_side)
  );

  logic           md_v;
  ssc_pkg::wide_t md_nhi, md_den;
  logic [P-1:0]   md_nlo;
  ssc_pkg::side_t md_side;

  ssc_mid u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d1_v),
    .q_i     (d1_q),
    .side_i  (d1_side),
    .valid_o (md_v),
    .nhi_o   (md_nhi),
    .nlo_o   (md_nlo),
    .den_o   (md_den),
    .side_o  (md_side)
  );

  // second division: t, or the recomputed s after t was clamped
  logic           d2_v;
  ssc_pkg::par_t  d2_q;
  ssc_pkg::side_t d2_side;

  ssc_div u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (md_v),
    .nhi_i   (md_nhi),
    .nlo_i   (md_nlo),
    .den_i   (md_den),
    .side_i  (md_side),
    .valid_o (d2_v),
    .q_o     (d2_q),
    .side_o  (d2_side)
  );

  // final s, t and d * param
  ssc_pkg::par_t s_fin, t_fin;
  logic          gen;

  always_comb begin
    gen   = !d2_side.a_deg && !d2_side.e_deg;
    s_fin = d2_side.s;
    t_fin = d2_side.t;
    if (gen) begin
      if (d2_side.tn_neg) begin
        t_fin = '0;
        s_fin = d2_q;
      end else if (d2_side.tn_gt) begin
        t_fin = ssc_pkg::PAR_ONE;
        s_fin = d2_q;
      end else begin
        t_fin = d2_q;
      end
    end
  end

  logic signed [A-1:0] prod_d [6], prod_q [6];
  logic [C-1:0]        base_q [6];
  logic                f1_v_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i]   = $signed(d2_side.g.d1[i]) * $signed({1'b0, s_fin});
      prod_d[3+i] = $signed(d2_side.g.d2[i]) * $signed({1'b0, t_fin});
    end
  end

  // truncate toward zero by 2^PAR_W, add to the start point
  logic signed [A-1:0] step [6];
  logic [C-1:0]        near_d [6];
  logic [C-1:0]        near_q [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      if (prod_q[k][A-1]) begin
        step[k] = (prod_q[k] + A'({P{1'b1}})) >>> P;
      end else begin
        step[k] = prod_q[k] >>> P;
      end
      near_d[k] = base_q[k] + step[k][C-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q  <= d2_v;
      out_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      for (int i = 0; i < 3; i++) begin
        base_q[i]   <= d2_side.g.p1[i];
        base_q[3+i] <= d2_side.g.p2[i];
      end
      near_q <= near_d;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < 6; k++) begin
      m_axis_tdata[k*C +: C] = near_q[k];
    end
  end

  assign m_axis_tvalid = out_v_q;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for segment_segment_closest_points_unit.
// A clocked driver feeds segment pairs from a queue and a clocked monitor
// checks each result against an in-order queue of predicted closest points.
// Both sides idle at random. One long back-pressure stretch fills the
// pipeline, and one request waits until the pipeline has drained.
module tb_top;

  localparam int CLK_HALF   = 6;
  localparam int RST_CYCLES = 9;
  localparam int N_RANDOM   = 1830;
  localparam int TAIL_WAIT  = 150;
  localparam int CYCLE_MAX  = 600000;
  localparam int HOLD_LEN   = 400;    // receiver hold-off, much longer than the pipe

  typedef logic signed [255:0] big_t;
  typedef logic [11:0][31:0]   pair_t;  // field 0 in the low bits, as on s_axis_tdata
  typedef logic [5:0][31:0]    near_t;

  typedef enum logic [2:0] {
    GEO_BOTH_DEG, GEO_SEG1_DEG, GEO_SEG2_DEG, GEO_PARALLEL,
    GEO_T_LOW, GEO_T_HIGH, GEO_INTERIOR
  } geo_case_e;

  typedef struct {
    pair_t pair;
    logic  drain;   // hold this request until nothing is outstanding
  } req_t;

  localparam big_t PAR_ONE_B = big_t'(1) <<< 32;
  localparam big_t EPS_B     = big_t'(4295);

  logic                      clk_i;
  logic                      rst_ni;
  logic [ssc_pkg::IN_W-1:0]  s_axis_tdata;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [ssc_pkg::OUT_W-1:0] m_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;

  segment_segment_closest_points_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  req_t  pending_q[$];
  near_t near_exp_q[$];
  int    err_cnt;
  int    req_cnt;
  int    res_cnt;
  int    cycle_cnt;
  int    case_cnt[7];
  bit    stim_done;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  // clamped ratio num/den in unsigned Q1.32
  function automatic big_t seg_param(big_t num, big_t den);
    if (num <= 0) return 0;
    if (num >= den) return PAR_ONE_B;
    return (num <<< 32) / den;
  endfunction

  // start + d * par, scaled back with truncation toward zero
  function automatic logic [31:0] point_along(big_t p, big_t d, big_t par);
    big_t sum;
    sum = p + (d * par) / PAR_ONE_B;
    return sum[31:0];
  endfunction

  function automatic near_t closest_points(pair_t pr, output geo_case_e kind);
    big_t  p1[3], p2[3], d1[3], d2[3], r[3];
    big_t  a, e, b, c, f, det, s, t, tn;
    near_t res;
    a = 0; e = 0; b = 0; c = 0; f = 0;
    for (int i = 0; i < 3; i++) begin
      p1[i] = big_t'($signed(pr[i]));
      p2[i] = big_t'($signed(pr[6+i]));
      d1[i] = big_t'($signed(pr[3+i])) - p1[i];
      d2[i] = big_t'($signed(pr[9+i])) - p2[i];
      r[i]  = p1[i] - p2[i];
    end
    for (int i = 0; i < 3; i++) begin
      a += d1[i] * d1[i];
      e += d2[i] * d2[i];
      b += d1[i] * d2[i];
      c += d1[i] * r[i];
      f += d2[i] * r[i];
    end
    s = 0;
    t = 0;
    if (a <= EPS_B && e <= EPS_B) begin
      kind = GEO_BOTH_DEG;
    end else if (a <= EPS_B) begin
      kind = GEO_SEG1_DEG;
      t = seg_param(f, e);
    end else if (e <= EPS_B) begin
      kind = GEO_SEG2_DEG;
      s = seg_param(-c, a);
    end else begin
      det = a * e - b * b;
      kind = (det == 0) ? GEO_PARALLEL : GEO_INTERIOR;
      s = (det == 0) ? big_t'(0) : seg_param(b * f - c * e, det);
      tn = b * s + (f <<< 32);
      if (tn < 0) begin
        if (kind != GEO_PARALLEL) kind = GEO_T_LOW;
        s = seg_param(-c, a);
      end else if (tn > (e <<< 32)) begin
        if (kind != GEO_PARALLEL) kind = GEO_T_HIGH;
        t = PAR_ONE_B;
        s = seg_param(b - c, a);
      end else begin
        t = tn / e;
      end
    end
    for (int i = 0; i < 3; i++) begin
      res[i]   = point_along(p1[i], d1[i], s);
      res[3+i] = point_along(p2[i], d2[i], t);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int small_val(int range);
    return int'($urandom_range(0, 2 * range)) - range;
  endfunction

  function automatic pair_t random_pair(int shape);
    pair_t pr;
    int    k;
    for (int i = 0; i < 12; i++) pr[i] = $urandom;
    case (shape)
      0: ;  // full range
      1: for (int i = 0; i < 12; i++) pr[i] = small_val(1 << 18);
      2: begin  // first segment shorter than the threshold
        for (int i = 0; i < 12; i++) pr[i] = small_val(1 << 20);
        for (int i = 0; i < 3; i++) pr[3+i] = pr[i] + small_val(37);
      end
      3: begin  // second segment degenerate
        for (int i = 0; i < 12; i++) pr[i] = small_val(1 << 20);
        for (int i = 0; i < 3; i++) pr[9+i] = pr[6+i] + small_val(37);
      end
      4: begin  // both degenerate, anywhere in range
        for (int i = 0; i < 3; i++) begin
          pr[3+i] = pr[i] + small_val(30);
          pr[9+i] = pr[6+i] + small_val(30);
        end
      end
      5: begin  // parallel: second direction an integer multiple of the first
        k = small_val(3);
        if (k == 0) k = 1;
        for (int i = 0; i < 3; i++) begin
          pr[i]   = small_val(1 << 20);
          pr[3+i] = pr[i] + small_val(1 << 18);
          pr[6+i] = small_val(1 << 20);
          pr[9+i] = pr[6+i] + k * ($signed(pr[3+i]) - $signed(pr[i]));
        end
      end
      default: for (int i = 0; i < 12; i++) pr[i] = small_val(1 << 8);
    endcase
    return pr;
  endfunction

  function automatic pair_t pair_of(int v[12]);
    pair_t pr;
    for (int i = 0; i < 12; i++) pr[i] = v[i];
    return pr;
  endfunction

  task automatic add_pair(pair_t pr, bit drain = 1'b0);
    req_t rq;
    rq.pair  = pr;
    rq.drain = drain;
    pending_q.insert(pending_q.size(), rq);
  endtask

  task automatic load_directed();
    int mn, mx, one;
    mn  = 32'h8000_0000;
    mx  = 32'h7fff_ffff;
    one = 1 << 16;
    add_pair(pair_of('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
    add_pair(pair_of('{mn, mn, mn, mx, mx, mx, mx, mn, mx, mn, mx, mn}));
    add_pair(pair_of('{mx, mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx}));
    add_pair(pair_of('{mn, mx, mn, mn, mx, mn, mx, mn, mx, mx, mn, mx}));   // both points
    add_pair(pair_of('{-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0}));
    // skew perpendicular lines, interior solution
    add_pair(pair_of('{-one, 0, 0, one, 0, 0, 0, -one, one, 0, one, one}));
    // first segment a point, second a line through and past it
    add_pair(pair_of('{one, one, 0, one, one, 0, 0, 0, 0, 4*one, 0, 0}));
    add_pair(pair_of('{-one, 0, 0, -one, 0, 0, 0, 0, 0, 4*one, 0, 0}));
    add_pair(pair_of('{9*one, 0, 0, 9*one, 0, 0, 0, 0, 0, 4*one, 0, 0}));
    // second segment a point
    add_pair(pair_of('{0, 0, 0, 4*one, 0, 0, 2*one, one, 0, 2*one, one, 0}));
    add_pair(pair_of('{0, 0, 0, 4*one, 0, 0, -one, one, 0, -one, one, 0}));
    // lengths on either side of the degenerate threshold for segment 1, under it for segment 2
    add_pair(pair_of('{0, 0, 0, 65, 7, 0, 0, one, 0, one, one, 0}));
    add_pair(pair_of('{0, 0, 0, 65, 10, 0, 0, one, 0, one, one, 0}));
    add_pair(pair_of('{0, 0, 0, one, one, 0, 5, 5, 5, 70, 5, 5}));
    add_pair(pair_of('{0, 0, 0, one, one, 0, 5, 5, 5, 65, 12, 5}));
    // parallel, overlapping and anti-parallel
    add_pair(pair_of('{0, 0, 0, 4*one, 0, 0, one, one, 0, 3*one, one, 0}));
    add_pair(pair_of('{0, 0, 0, 4*one, 0, 0, 6*one, one, 0, 5*one, one, 0}));
    add_pair(pair_of('{0, 0, 0, 4*one, 0, 0, -3*one, one, 0, -2*one, one, 0}));
    // skew segments clamping t low and t high
    add_pair(pair_of('{0, 0, 0, 4*one, 0, 0, 2*one, 2*one, one, 2*one, 5*one, one}));
    add_pair(pair_of('{0, 0, 0, 4*one, 0, 0, 2*one, -5*one, one, 2*one, -2*one, one}));
    add_pair(pair_of('{0, 0, 0, one, 0, 0, 5*one, -one, 0, 5*one, one, one}));
    add_pair(pair_of('{0, 0, 0, one, 0, 0, -5*one, -one, 0, -5*one, one, one}));
  endtask

  initial begin
    int shape;
    err_cnt   = 0;
    stim_done = 1'b0;
    load_directed();
    for (int n = 0; n < N_RANDOM; n++) begin
      shape = $urandom_range(0, 9);
      if (shape > 6) shape = $urandom_range(0, 1);
      add_pair(random_pair(shape), n == N_RANDOM / 2);
    end
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------- reset

  initial begin
    rst_ni = 1'b0;
    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int idle_len(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------- driver

  bit in_taken;    // request accepted at the last rising edge
  int in_gap;
  bit in_calm;
  int in_phase;

  always @(posedge clk_i) begin
    in_taken <= s_axis_tvalid && s_axis_tready;
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      in_gap        <= 0;
      in_calm       <= 1'b0;
      in_phase      <= 0;
    end else begin
      if (in_phase == 0) begin
        in_calm  <= $urandom_range(0, 3) == 0;
        in_phase <= $urandom_range(50, 250);
      end else begin
        in_phase <= in_phase - 1;
      end
      if (s_axis_tvalid && !in_taken) begin
        // hold the offered request until it is taken
      end else if (in_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap        <= in_gap - 1;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].drain && near_exp_q.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tdata  <= pending_q[0].pair;
        s_axis_tvalid <= 1'b1;
        pending_q.pop_front();
        in_gap        <= idle_len(in_calm);
      end
    end
  end

  // predict on every accepted request
  always @(posedge clk_i) begin
    geo_case_e kind;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      near_exp_q.insert(near_exp_q.size(), closest_points(s_axis_tdata, kind));
      case_cnt[kind] = case_cnt[kind] + 1;
      req_cnt = req_cnt + 1;
    end
  end

  // ---------------------------------------------------------------- receiver

  int  out_gap;
  bit  out_calm;
  int  out_phase;
  int  hold_cnt;    // long back-pressure stretch, counted in cycles
  bit  hold_done;

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_gap       <= 0;
      out_calm      <= 1'b0;
      out_phase     <= 0;
      hold_cnt      <= 0;
      hold_done     <= 1'b0;
    end else begin
      if (out_phase == 0) begin
        out_calm  <= $urandom_range(0, 3) == 0;
        out_phase <= $urandom_range(50, 250);
      end else begin
        out_phase <= out_phase - 1;
      end
      if (!hold_done && req_cnt >= 300) begin
        m_axis_tready <= 1'b0;
        hold_cnt      <= hold_cnt + 1;
        if (hold_cnt == HOLD_LEN) hold_done <= 1'b1;
      end else if (out_gap > 0) begin
        m_axis_tready <= 1'b0;
        out_gap       <= out_gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
        out_gap       <= idle_len(out_calm);
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(string what, int idx, logic [31:0] got, logic [31:0] want);
    $display("mismatch result %0d %s: got %h expected %h", idx, what, got, want);
    err_cnt++;
  endtask

  string near_names[6] = '{"near1_x", "near1_y", "near1_z", "near2_x", "near2_y", "near2_z"};

  always @(posedge clk_i) begin
    near_t got;
    near_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (near_exp_q.size() == 0) begin
        $display("result %0d arrived with no request outstanding", res_cnt);
        err_cnt++;
      end else begin
        want = near_exp_q.pop_front();
        for (int i = 0; i < 6; i++)
          if (got[i] !== want[i]) report_mismatch(near_names[i], res_cnt, got[i], want[i]);
      end
      res_cnt = res_cnt + 1;
    end
  end

  // ---------------------------------------------------------------- end of run

  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("timeout with %0d results outstanding", near_exp_q.size());
      $display("** segment_segment_closest_points_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    req_cnt   = 0;
    res_cnt   = 0;
    cycle_cnt = 0;
    for (int i = 0; i < 7; i++) case_cnt[i] = 0;
    wait (stim_done);
    @(posedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || near_exp_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    $display("%0d segment pairs checked: both degenerate %0d, one degenerate %0d/%0d,",
             res_cnt, case_cnt[GEO_BOTH_DEG], case_cnt[GEO_SEG1_DEG], case_cnt[GEO_SEG2_DEG]);
    $display("parallel %0d, t clamped low %0d / high %0d, interior %0d; %0d mismatches",
             case_cnt[GEO_PARALLEL], case_cnt[GEO_T_LOW], case_cnt[GEO_T_HIGH],
             case_cnt[GEO_INTERIOR], err_cnt);
    if (err_cnt == 0 && near_exp_q.size() == 0) begin
      $display("** segment_segment_closest_points_unit: PASSED **");
    end else begin
      $display("** segment_segment_closest_points_unit: FAILED **");
    end
    $finish;
  end

endmodule
